// ----- sv/fba_pkg.sv -----
`timescale 1ns / 1ps
package fba_pkg;

  localparam int NUM_ENTRIES     = 16;
  localparam int NUM_BLOCKS      = 128;
  localparam int MAX_FILE_BLOCKS = 8;

  typedef enum logic [1:0] {
    KIND_CREATE    = 2'd0,
    KIND_DELETE    = 2'd1,
    KIND_TRANSLATE = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NAME_USED   = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_NO_ENTRY    = 3'd3,
    ST_NO_SPACE    = 3'd4,
    ST_NOT_FOUND   = 3'd5,
    ST_INDEX_RANGE = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_SCAN,
    S_COMMIT,
    S_FREE,
    S_PTR_RD,
    S_PTR_WAIT,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic free_start;
    logic undo_start;
    logic free_step;
    logic del_commit;
    logic ptr_rd;
    logic set_result;
    status_e result_status;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  hit;
    logic  too_large;
    logic  has_free_entry;
    logic  scan_done;
    logic  scan_enough;
    logic  free_done;
    logic  index_bad;
    logic  out_full;
  } sts_t;

endpackage

// ----- sv/file_block_allocator.sv -----
`timescale 1ns / 1ps
// File table with a free-block map.
// Input channel (in_valid_i/in_ready_o) carries one command word: create,
// delete or translate, with a name, a size and a block index. Output channel
// (out_valid_o/out_ready_i) returns one status word per command.
// Commands are handled one at a time; in_ready_o is high only while idle.
// An error found at lookup is set in the result register in S_DECIDE and
// moved to the output register in S_OUT; the controller then returns to idle.
// A translate reads its pointer in S_PTR_RD and sets its result in S_PTR_WAIT.
// A delete frees its blocks in S_FREE, reading one pointer per cycle. A create
// walks the block map one block per cycle from block 1 until it has enough.
// A create that runs out of blocks walks the whole map and then gives back
// the blocks it marked, in S_FREE.
// Reset clears the table and the block map at once; no clearing pass.
// When the receiver stalls, the finished word waits in the output register and
// the next command may be accepted; it waits before loading its own result.
module file_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] file_name_i,
  input  logic [3:0]  file_size_i,
  input  logic [2:0]  block_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  entry_index_o,
  output logic [6:0]  block_number_o,
  output logic [3:0]  blocks_in_file_o
);
  import fba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fba_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (kind_i),
    .file_name_i      (file_name_i),
    .file_size_i      (file_size_i),
    .block_index_i    (block_index_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .entry_index_o    (entry_index_o),
    .block_number_o   (block_number_o),
    .blocks_in_file_o (blocks_in_file_o)
  );

endmodule

// ----- sv/fba_datapath.sv -----
`timescale 1ns / 1ps
module fba_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fba_pkg::cmd_t  cmd_i,
  output fba_pkg::sts_t  sts_o,
  input  logic [1:0]     kind_i,
  input  logic [63:0]    file_name_i,
  input  logic [3:0]     file_size_i,
  input  logic [2:0]     block_index_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [2:0]     status_o,
  output logic [3:0]     entry_index_o,
  output logic [6:0]     block_number_o,
  output logic [3:0]     blocks_in_file_o
);
  import fba_pkg::*;

  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int SW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
  localparam int PD = NUM_ENTRIES * MAX_FILE_BLOCKS;
  localparam int PW = EW + SW;

  logic [NUM_ENTRIES-1:0] valid_q;
  logic [63:0]            label_q [NUM_ENTRIES];
  logic [3:0]             length_q [NUM_ENTRIES];
  logic [NUM_BLOCKS-1:0]  taken_q;
  logic [BW-1:0]          ptr_mem [PD];

  logic [1:0]    kind_q;
  logic [63:0]   name_q;
  logic [3:0]    size_q;
  logic [2:0]    bidx_q;
  logic          hit_q;
  logic [EW-1:0] hit_idx_q;
  logic [EW-1:0] free_idx_q;
  logic          free_any_q;
  logic [BW:0]   blk_q;
  logic [4:0]    cnt_q;
  logic [3:0]    lim_q;
  logic [EW-1:0] base_q;
  logic [BW-1:0] ptr_rd_q;
  logic          out_valid_q;
  logic [2:0]    st_q;
  logic [3:0]    ent_q;
  logic [6:0]    bn_q;
  logic [3:0]    len_q;
  logic [2:0]    out_st_q;
  logic [3:0]    out_ent_q;
  logic [6:0]    out_bn_q;
  logic [3:0]    out_len_q;

  logic [NUM_ENTRIES-1:0] match;
  logic          hit_d;
  logic [EW-1:0] hit_idx_d;
  logic          free_any_d;
  logic [EW-1:0] free_idx_d;
  logic [3:0]    hit_len;
  logic          ptr_we;
  logic [PW-1:0] ptr_wa;
  logic [PW-1:0] ptr_ra;

  always_comb begin
    hit_d = 1'b0;
    hit_idx_d = '0;
    free_any_d = 1'b0;
    free_idx_d = '0;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      match[e] = valid_q[e] && (label_q[e] == name_q);
      if (match[e]) begin
        hit_d = 1'b1;
        hit_idx_d = EW'(e);
      end
      if (!valid_q[e]) begin
        free_any_d = 1'b1;
        free_idx_d = EW'(e);
      end
    end
  end

  assign hit_len = length_q[hit_idx_q];

  assign ptr_we = cmd_i.scan_step && !taken_q[blk_q[BW-1:0]] && (cnt_q < 5'(size_q));
  assign ptr_wa = {free_idx_q, cnt_q[SW-1:0]};
  assign ptr_ra = cmd_i.ptr_rd ? {hit_idx_q, bidx_q[SW-1:0]} : {base_q, cnt_q[SW-1:0]};

  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[ptr_wa] <= blk_q[BW-1:0];
    end
    ptr_rd_q <= ptr_mem[ptr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      name_q <= file_name_i;
      size_q <= file_size_i;
      bidx_q <= block_index_i;
    end
    if (cmd_i.lookup) begin
      hit_q <= hit_d;
      hit_idx_q <= hit_idx_d;
      free_any_q <= free_any_d;
      free_idx_q <= free_idx_d;
    end
    if (cmd_i.scan_start) begin
      blk_q <= (BW + 1)'(1);
      cnt_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (ptr_we) begin
        cnt_q <= cnt_q + 5'd1;
      end
      blk_q <= blk_q + (BW + 1)'(1);
    end else if (cmd_i.free_start) begin
      cnt_q <= '0;
      lim_q <= hit_len;
      base_q <= hit_idx_q;
    end else if (cmd_i.undo_start) begin
      cnt_q <= '0;
      lim_q <= cnt_q[3:0];
      base_q <= free_idx_q;
    end else if (cmd_i.free_step) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      taken_q <= '0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        label_q[e] <= '0;
        length_q[e] <= '0;
      end
    end else begin
      if (ptr_we) begin
        taken_q[blk_q[BW-1:0]] <= 1'b1;
      end
      if (cmd_i.commit) begin
        valid_q[free_idx_q] <= 1'b1;
        label_q[free_idx_q] <= name_q;
        length_q[free_idx_q] <= size_q;
      end
      // Pointer read issued in previous step lands in ptr_rd_q now.
      if (cmd_i.free_step && cnt_q != 5'd0) begin
        taken_q[ptr_rd_q] <= 1'b0;
      end
      if (cmd_i.del_commit) begin
        valid_q[hit_idx_q] <= 1'b0;
        label_q[hit_idx_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      st_q <= cmd_i.result_status;
      ent_q <= '0;
      bn_q <= '0;
      len_q <= '0;
      unique case (cmd_i.result_status)
        ST_NAME_USED, ST_INDEX_RANGE: begin
          ent_q <= 4'(hit_idx_q);
          len_q <= hit_len;
        end
        ST_OK: begin
          if (kind_q == KIND_CREATE) begin
            ent_q <= 4'(free_idx_q);
            len_q <= size_q;
          end else begin
            ent_q <= 4'(hit_idx_q);
            len_q <= hit_len;
            if (kind_q == KIND_TRANSLATE) begin
              bn_q <= 7'(ptr_rd_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_st_q <= st_q;
      out_ent_q <= ent_q;
      out_bn_q <= bn_q;
      out_len_q <= len_q;
    end
  end

  assign sts_o.kind           = kind_e'(kind_q);
  assign sts_o.hit            = hit_q;
  assign sts_o.too_large      = size_q > 4'(MAX_FILE_BLOCKS);
  assign sts_o.has_free_entry = free_any_q;
  assign sts_o.scan_enough    = cnt_q >= 5'(size_q);
  assign sts_o.scan_done      = blk_q == (BW + 1)'(NUM_BLOCKS);
  assign sts_o.free_done      = cnt_q >= 5'(lim_q);
  assign sts_o.index_bad      = (4'(bidx_q) >= hit_len) || (32'(bidx_q) >= MAX_FILE_BLOCKS);
  assign sts_o.out_full       = out_valid_q;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign entry_index_o    = out_ent_q;
  assign block_number_o   = out_bn_q;
  assign blocks_in_file_o = out_len_q;

endmodule

// ----- sv/fba_ctrl.sv -----
`timescale 1ns / 1ps
module fba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fba_pkg::sts_t sts_i,
  output fba_pkg::cmd_t cmd_o
);
  import fba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = S_OUT;
        if (sts_i.kind == KIND_CREATE) begin
          if (!sts_i.hit && !sts_i.too_large && sts_i.has_free_entry) begin
            state_d = S_SCAN;
          end
        end else if (sts_i.hit && sts_i.kind == KIND_DELETE) begin
          state_d = S_FREE;
        end else if (sts_i.hit && sts_i.kind == KIND_TRANSLATE && !sts_i.index_bad) begin
          state_d = S_PTR_RD;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_enough) begin
          state_d = S_OUT;
        end else if (sts_i.scan_done) begin
          state_d = S_FREE;
        end
      end
      S_FREE:     if (sts_i.free_done) state_d = S_OUT;
      S_PTR_RD:   state_d = S_PTR_WAIT;
      S_PTR_WAIT: state_d = S_OUT;
      S_OUT:      if (!sts_i.out_full) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.result_status = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_LOOKUP: cmd_o.lookup = 1'b1;
      S_DECIDE: begin
        cmd_o.set_result = 1'b1;
        if (sts_i.kind == KIND_CREATE) begin
          if (sts_i.hit) begin
            cmd_o.result_status = ST_NAME_USED;
          end else if (sts_i.too_large) begin
            cmd_o.result_status = ST_TOO_LARGE;
          end else if (!sts_i.has_free_entry) begin
            cmd_o.result_status = ST_NO_ENTRY;
          end else begin
            cmd_o.set_result = 1'b0;
            cmd_o.scan_start = 1'b1;
          end
        end else if (!sts_i.hit || sts_i.kind == KIND_UNUSED) begin
          cmd_o.result_status = ST_NOT_FOUND;
        end else if (sts_i.kind == KIND_DELETE) begin
          cmd_o.free_start = 1'b1;
        end else if (sts_i.index_bad) begin
          cmd_o.result_status = ST_INDEX_RANGE;
        end else begin
          cmd_o.set_result = 1'b0;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_enough) begin
          cmd_o.set_result = 1'b1;
          cmd_o.commit = 1'b1;
        end else if (sts_i.scan_done) begin
          // Not enough free blocks: give back the ones marked during the scan.
          cmd_o.set_result = 1'b1;
          cmd_o.result_status = ST_NO_SPACE;
          cmd_o.undo_start = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FREE: begin
        cmd_o.free_step = 1'b1;
        if (sts_i.free_done && sts_i.kind == KIND_DELETE) begin
          cmd_o.del_commit = 1'b1;
        end
      end
      S_PTR_RD:   cmd_o.ptr_rd = 1'b1;
      S_PTR_WAIT: cmd_o.set_result = 1'b1;
      S_OUT:      cmd_o.out_load = !sts_i.out_full;
      default: ;
    endcase
  end

endmodule

// ----- sv/fba_checker.sv -----
`timescale 1ns / 1ps
module fba_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [6:0] block_number_o
);
  import fba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("output word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7)
    else $error("undefined status code");

  a_err_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> block_number_o == 7'd0)
    else $error("block number on error");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted two commands back to back");

endmodule

bind file_block_allocator fba_checker u_fba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .block_number_o (block_number_o)
);
